// ===== rtl/dpcr_pkg.sv =====
// Shared types, constants and arithmetic step functions for the disc pair
// collision resolver. No dependencies.
package dpcr_pkg;

  localparam int NBITS = 30;
  localparam int DIV_BITS = 32;
  localparam int STEPS_PER_STAGE = 2;
  localparam int PIPE_STAGES = DIV_BITS / STEPS_PER_STAGE;

  localparam logic [14:0] TEMP_CAP = 15'd25600;
  localparam logic [14:0] ONE_Q14 = 15'd16384;
  localparam logic [63:0] HEAT_Q_CAP = 64'd640000;
  localparam logic [27:0] DIV25_K = 28'd171798692;

  localparam logic [0:0] REG_DISC_RADIUS = 1'b0;
  localparam logic [0:0] REG_RESTITUTION = 1'b1;

  localparam logic [1:0] OUTCOME_NONE = 2'd0;
  localparam logic [1:0] OUTCOME_COINCIDENT = 2'd1;
  localparam logic [1:0] OUTCOME_SEPARATED = 2'd2;
  localparam logic [1:0] OUTCOME_BOUNCED = 2'd3;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic [31:0]        a_mass;
    logic [31:0]        b_mass;
    logic [14:0]        a_temp;
    logic [14:0]        b_temp;
  } dpcr_in_t;

  typedef struct packed {
    logic signed [31:0] new_a_pos_x;
    logic signed [31:0] new_a_pos_y;
    logic signed [31:0] new_b_pos_x;
    logic signed [31:0] new_b_pos_y;
    logic signed [31:0] new_a_vel_x;
    logic signed [31:0] new_a_vel_y;
    logic signed [31:0] new_b_vel_x;
    logic signed [31:0] new_b_vel_y;
    logic [14:0]        new_a_temp;
    logic [14:0]        new_b_temp;
    logic [1:0]         outcome;
  } dpcr_out_t;

  typedef struct packed {
    dpcr_in_t           pair;
    logic               dx_neg;
    logic               dy_neg;
    logic [31:0]        mdx;
    logic [31:0]        mdy;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic               contact;
  } dpcr_base_t;

  typedef struct packed {
    dpcr_base_t  base;
    logic [63:0] dsq;
    logic [63:0] mmul;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [32:0] msum;
  } dpcr_front_t;

  typedef struct packed {
    dpcr_base_t  base;
    logic [31:0] d;
    logic [31:0] ra;
    logic [31:0] rb;
    logic [31:0] mu;
  } dpcr_root_t;

  typedef struct packed {
    dpcr_root_t  root;
    logic [31:0] nxm;
    logic [31:0] nym;
  } dpcr_norm_t;

  typedef struct packed {
    logic [32:0] rem;
    logic        q;
  } div_step_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] root;
  } sqrt_step_t;

  function automatic div_step_t div_step(input logic [32:0] rem, input logic [32:0] dvs,
                                         input logic b);
    logic [33:0] t;
    div_step_t   r;
    t = {rem, b};
    if (t >= {1'b0, dvs}) begin
      r.rem = 33'(t - {1'b0, dvs});
      r.q = 1'b1;
    end else begin
      r.rem = t[32:0];
      r.q = 1'b0;
    end
    return r;
  endfunction

  function automatic sqrt_step_t sqrt_step(input logic [32:0] rem, input logic [31:0] root,
                                           input logic [1:0] b);
    logic [34:0] t;
    logic [34:0] trial;
    sqrt_step_t  r;
    t = {rem, b};
    trial = {1'b0, root, 2'b01};
    if (t >= trial) begin
      r.rem = 33'(t - trial);
      r.root = {root[30:0], 1'b1};
    end else begin
      r.rem = t[32:0];
      r.root = {root[30:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? 33'(~v + 33'd1) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic [36:0] v);
    if (v[36:31] == {6{v[36]}}) begin
      return v[31:0];
    end
    return v[36] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // base +/- magnitude, sign taken from the normal direction, saturated
  function automatic logic [31:0] nudge(input logic [31:0] base, input logic [34:0] m,
                                        input logic neg);
    logic [36:0] b37;
    logic [36:0] m37;
    b37 = {{5{base[31]}}, base};
    m37 = {2'b00, m};
    return sat32(neg ? 37'(b37 - m37) : 37'(b37 + m37));
  endfunction

endpackage

// ===== rtl/dpcr_front.sv =====
// Front stages: center deltas, contact test and squared distance.
// Depends on dpcr_pkg.
module dpcr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  dpcr_pkg::dpcr_in_t    pair,
  input  logic [30:0]           disc_radius,
  output logic                  out_valid,
  output dpcr_pkg::dpcr_front_t front
);
  import dpcr_pkg::*;

  typedef struct packed {
    dpcr_base_t  base;
    logic        lt;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [32:0] msum;
  } f1_t;

  typedef struct packed {
    dpcr_base_t  base;
    logic        lt;
    logic [63:0] dx2;
    logic [63:0] dy2;
    logic [63:0] minsq;
    logic [63:0] mmul;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [32:0] msum;
  } f2_t;

  logic [31:0] twor;
  logic [32:0] dx;
  logic [32:0] dy;
  logic [32:0] mdx;
  logic [32:0] mdy;
  f1_t         s1;
  f1_t         s1_next;
  f2_t         s2;
  f2_t         s2_next;
  dpcr_front_t s3_next;
  logic        v1;
  logic        v2;

  assign twor = {disc_radius, 1'b0};

  always_comb begin
    dx = {pair.a_pos_x[31], pair.a_pos_x} - {pair.b_pos_x[31], pair.b_pos_x};
    dy = {pair.a_pos_y[31], pair.a_pos_y} - {pair.b_pos_y[31], pair.b_pos_y};
    mdx = mag33(dx);
    mdy = mag33(dy);
    s1_next.base.pair = pair;
    s1_next.base.dx_neg = dx[32];
    s1_next.base.dy_neg = dy[32];
    s1_next.base.mdx = mdx[31:0];
    s1_next.base.mdy = mdy[31:0];
    s1_next.base.rvx = {pair.a_vel_x[31], pair.a_vel_x} - {pair.b_vel_x[31], pair.b_vel_x};
    s1_next.base.rvy = {pair.a_vel_y[31], pair.a_vel_y} - {pair.b_vel_y[31], pair.b_vel_y};
    s1_next.base.contact = 1'b0;
    s1_next.lt = (mdx < {1'b0, twor}) && (mdy < {1'b0, twor});
    s1_next.ma = (pair.a_mass == '0) ? 32'd1 : pair.a_mass;
    s1_next.mb = (pair.b_mass == '0) ? 32'd1 : pair.b_mass;
    s1_next.msum = {1'b0, s1_next.ma} + {1'b0, s1_next.mb};
  end

  always_comb begin
    s2_next.base = s1.base;
    s2_next.lt = s1.lt;
    s2_next.dx2 = s1.base.mdx * s1.base.mdx;
    s2_next.dy2 = s1.base.mdy * s1.base.mdy;
    s2_next.minsq = twor * twor;
    s2_next.mmul = s1.ma * s1.mb;
    s2_next.ma = s1.ma;
    s2_next.mb = s1.mb;
    s2_next.msum = s1.msum;
  end

  always_comb begin
    s3_next.base = s2.base;
    s3_next.base.contact = s2.lt && (s2.dx2 < s2.minsq) && (s2.dy2 < (s2.minsq - s2.dx2));
    s3_next.dsq = s2.dx2 + s2.dy2;
    s3_next.mmul = s2.mmul;
    s3_next.ma = s2.ma;
    s3_next.mb = s2.mb;
    s3_next.msum = s2.msum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      front <= s3_next;
    end
  end

endmodule

// ===== rtl/dpcr_root.sv =====
// Square root of the squared distance and the mass ratio divisions,
// two bits per stage. Depends on dpcr_pkg.
module dpcr_root (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  dpcr_pkg::dpcr_front_t front,
  output logic                  out_valid,
  output dpcr_pkg::dpcr_root_t  root
);
  import dpcr_pkg::*;

  typedef struct packed {
    dpcr_base_t  base;
    logic [32:0] msum;
    logic [32:0] sq_rem;
    logic [31:0] sq_root;
    logic [63:0] sq_rest;
    logic [32:0] ra_rem;
    logic [32:0] rb_rem;
    logic [32:0] mu_rem;
    logic [31:0] ra_q;
    logic [31:0] rb_q;
    logic [31:0] mu_q;
    logic [31:0] ra_rest;
    logic [31:0] rb_rest;
    logic [31:0] mu_rest;
  } root_stage_t;

  function automatic root_stage_t root_advance(input root_stage_t c);
    root_stage_t n;
    sqrt_step_t  sq;
    div_step_t   da;
    div_step_t   db;
    div_step_t   dm;
    n = c;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      sq = sqrt_step(n.sq_rem, n.sq_root, n.sq_rest[63:62]);
      n.sq_rem = sq.rem;
      n.sq_root = sq.root;
      n.sq_rest = {n.sq_rest[61:0], 2'b00};
      da = div_step(n.ra_rem, n.msum, n.ra_rest[31]);
      db = div_step(n.rb_rem, n.msum, n.rb_rest[31]);
      dm = div_step(n.mu_rem, n.msum, n.mu_rest[31]);
      n.ra_rem = da.rem;
      n.rb_rem = db.rem;
      n.mu_rem = dm.rem;
      n.ra_q = {n.ra_q[30:0], da.q};
      n.rb_q = {n.rb_q[30:0], db.q};
      n.mu_q = {n.mu_q[30:0], dm.q};
      n.ra_rest = {n.ra_rest[30:0], 1'b0};
      n.rb_rest = {n.rb_rest[30:0], 1'b0};
      n.mu_rest = {n.mu_rest[30:0], 1'b0};
    end
    return n;
  endfunction

  root_stage_t src;
  root_stage_t stg [PIPE_STAGES];
  logic        vld [PIPE_STAGES];

  always_comb begin
    src.base = front.base;
    src.msum = front.msum;
    src.sq_rem = '0;
    src.sq_root = '0;
    src.sq_rest = front.dsq;
    src.ra_rem = {3'b000, front.mb[31:2]};
    src.rb_rem = {3'b000, front.ma[31:2]};
    src.mu_rem = {1'b0, front.mmul[63:32]};
    src.ra_q = '0;
    src.rb_q = '0;
    src.mu_q = '0;
    src.ra_rest = {front.mb[1:0], 30'd0};
    src.rb_rest = {front.ma[1:0], 30'd0};
    src.mu_rest = front.mmul[31:0];
  end

  for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_stage
    root_stage_t cur;
    logic        cur_v;
    if (k == 0) begin : g_first
      assign cur = src;
      assign cur_v = in_valid;
    end else begin : g_next
      assign cur = stg[k-1];
      assign cur_v = vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= cur_v;
      end
      if (adv) begin
        stg[k] <= root_advance(cur);
      end
    end
  end

  assign out_valid = vld[PIPE_STAGES-1];
  assign root.base = stg[PIPE_STAGES-1].base;
  assign root.d = stg[PIPE_STAGES-1].sq_root;
  assign root.ra = stg[PIPE_STAGES-1].ra_q;
  assign root.rb = stg[PIPE_STAGES-1].rb_q;
  assign root.mu = stg[PIPE_STAGES-1].mu_q;

  a_ratio_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && root.base.contact |->
      (33'(root.ra) + 33'(root.rb) == 33'(1) << NBITS) ||
      (33'(root.ra) + 33'(root.rb) == (33'(1) << NBITS) - 33'd1))
    else $error("mass ratios do not sum to one");

endmodule

// ===== rtl/dpcr_norm.sv =====
// Unit normal components: center delta over distance, two bits per stage.
// Depends on dpcr_pkg.
module dpcr_norm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  dpcr_pkg::dpcr_root_t root,
  output logic                 out_valid,
  output dpcr_pkg::dpcr_norm_t norm
);
  import dpcr_pkg::*;

  typedef struct packed {
    dpcr_root_t  root;
    logic [32:0] x_rem;
    logic [32:0] y_rem;
    logic [31:0] x_q;
    logic [31:0] y_q;
    logic [31:0] x_rest;
    logic [31:0] y_rest;
  } norm_stage_t;

  function automatic norm_stage_t norm_advance(input norm_stage_t c);
    norm_stage_t n;
    div_step_t   dx;
    div_step_t   dy;
    n = c;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      dx = div_step(n.x_rem, {1'b0, n.root.d}, n.x_rest[31]);
      dy = div_step(n.y_rem, {1'b0, n.root.d}, n.y_rest[31]);
      n.x_rem = dx.rem;
      n.y_rem = dy.rem;
      n.x_q = {n.x_q[30:0], dx.q};
      n.y_q = {n.y_q[30:0], dy.q};
      n.x_rest = {n.x_rest[30:0], 1'b0};
      n.y_rest = {n.y_rest[30:0], 1'b0};
    end
    return n;
  endfunction

  norm_stage_t src;
  norm_stage_t stg [PIPE_STAGES];
  logic        vld [PIPE_STAGES];

  always_comb begin
    src.root = root;
    src.x_rem = {3'b000, root.base.mdx[31:2]};
    src.y_rem = {3'b000, root.base.mdy[31:2]};
    src.x_q = '0;
    src.y_q = '0;
    src.x_rest = {root.base.mdx[1:0], 30'd0};
    src.y_rest = {root.base.mdy[1:0], 30'd0};
  end

  for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_stage
    norm_stage_t cur;
    logic        cur_v;
    if (k == 0) begin : g_first
      assign cur = src;
      assign cur_v = in_valid;
    end else begin : g_next
      assign cur = stg[k-1];
      assign cur_v = vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= cur_v;
      end
      if (adv) begin
        stg[k] <= norm_advance(cur);
      end
    end
  end

  assign out_valid = vld[PIPE_STAGES-1];
  assign norm.root = stg[PIPE_STAGES-1].root;
  assign norm.nxm = stg[PIPE_STAGES-1].x_q;
  assign norm.nym = stg[PIPE_STAGES-1].y_q;

  a_unit_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && norm.root.base.contact && (norm.root.d != '0) |->
      (norm.nxm <= (32'd1 << NBITS)) && (norm.nym <= (32'd1 << NBITS)))
    else $error("normal component above one");

endmodule

// ===== rtl/dpcr_resp.sv =====
// Response stages: separation moves, impulse, heating and saturation.
// Depends on dpcr_pkg.
module dpcr_resp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_valid,
  input  dpcr_pkg::dpcr_norm_t norm,
  input  logic [30:0]          disc_radius,
  input  logic [14:0]          restitution,
  output logic                 out_valid,
  output dpcr_pkg::dpcr_out_t  result
);
  import dpcr_pkg::*;

  localparam int HEAT_SHIFT = 2 * FRAC_BITS - 6;

  typedef struct packed {
    dpcr_norm_t  n;
    logic        sep;
    logic [31:0] sha;
    logic [31:0] shb;
    logic        tx_neg;
    logic        ty_neg;
    logic [63:0] txm;
    logic [63:0] tym;
  } r1_t;

  typedef struct packed {
    dpcr_norm_t  n;
    logic        sep;
    logic        bounce;
    logic [31:0] pxa;
    logic [31:0] pya;
    logic [31:0] pxb;
    logic [31:0] pyb;
    logic [33:0] vnm;
  } r2_t;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] bx;
    logic [31:0] by;
  } pos_t;

  typedef struct packed {
    dpcr_norm_t  n;
    logic        sep;
    logic        bounce;
    pos_t        pos;
    logic [34:0] s;
  } r3_t;

  typedef struct packed {
    dpcr_norm_t  n;
    logic        sep;
    logic        bounce;
    pos_t        pos;
    logic [34:0] dva;
    logic [34:0] dvb;
    logic [66:0] hp;
  } r4_t;

  typedef struct packed {
    dpcr_norm_t  n;
    logic        sep;
    logic        bounce;
    pos_t        pos;
    logic [34:0] vxa;
    logic [34:0] vya;
    logic [34:0] vxb;
    logic [34:0] vyb;
    logic        hcap;
    logic [47:0] qk;
  } r5_t;

  r1_t         r1;
  r1_t         r1_next;
  r2_t         r2;
  r2_t         r2_next;
  r3_t         r3;
  r3_t         r3_next;
  r4_t         r4;
  r4_t         r4_next;
  r5_t         r5;
  r5_t         r5_next;
  dpcr_out_t   r6_next;
  logic        v1;
  logic        v2;
  logic        v3;
  logic        v4;
  logic        v5;

  logic [31:0] twor;
  logic [31:0] ov;
  logic [63:0] pa;
  logic [63:0] pb;
  logic [32:0] rvxm;
  logic [32:0] rvym;
  logic [63:0] p_xa;
  logic [63:0] p_ya;
  logic [63:0] p_xb;
  logic [63:0] p_yb;
  logic [65:0] txs;
  logic [65:0] tys;
  logic [65:0] vn;
  logic [65:0] vnmag;
  logic [14:0] e;
  logic [15:0] ek;
  logic [49:0] sprod;
  logic [66:0] dva_p;
  logic [66:0] dvb_p;
  logic [66:0] vxa_p;
  logic [66:0] vya_p;
  logic [66:0] vxb_p;
  logic [66:0] vyb_p;
  logic [63:0] q;
  logic [14:0] heat;
  logic [15:0] ta_sum;
  logic [15:0] tb_sum;

  assign twor = {disc_radius, 1'b0};

  always_comb begin
    ov = twor - norm.root.d;
    pa = ov * norm.root.ra;
    pb = ov * norm.root.rb;
    rvxm = mag33(norm.root.base.rvx);
    rvym = mag33(norm.root.base.rvy);
    r1_next.n = norm;
    r1_next.sep = norm.root.base.contact && (norm.root.d != '0);
    r1_next.sha = pa[61:30];
    r1_next.shb = pb[61:30];
    r1_next.tx_neg = norm.root.base.rvx[32] ^ norm.root.base.dx_neg;
    r1_next.ty_neg = norm.root.base.rvy[32] ^ norm.root.base.dy_neg;
    r1_next.txm = rvxm * norm.nxm;
    r1_next.tym = rvym * norm.nym;
  end

  always_comb begin
    p_xa = r1.sha * r1.n.nxm;
    p_ya = r1.sha * r1.n.nym;
    p_xb = r1.shb * r1.n.nxm;
    p_yb = r1.shb * r1.n.nym;
    txs = r1.tx_neg ? 66'(-{2'b00, r1.txm}) : {2'b00, r1.txm};
    tys = r1.ty_neg ? 66'(-{2'b00, r1.tym}) : {2'b00, r1.tym};
    vn = txs + tys;
    vnmag = vn[65] ? 66'(-vn) : vn;
    r2_next.n = r1.n;
    r2_next.sep = r1.sep;
    r2_next.bounce = r1.sep && vn[65];
    r2_next.pxa = p_xa[61:30];
    r2_next.pya = p_ya[61:30];
    r2_next.pxb = p_xb[61:30];
    r2_next.pyb = p_yb[61:30];
    r2_next.vnm = vnmag[63:30];
  end

  always_comb begin
    e = (restitution > ONE_Q14) ? ONE_Q14 : restitution;
    ek = {1'b0, ONE_Q14} + {1'b0, e};
    sprod = r2.vnm * ek;
    r3_next.n = r2.n;
    r3_next.sep = r2.sep;
    r3_next.bounce = r2.bounce;
    r3_next.pos.ax = nudge(r2.n.root.base.pair.a_pos_x, {3'b000, r2.pxa},
                           r2.n.root.base.dx_neg);
    r3_next.pos.ay = nudge(r2.n.root.base.pair.a_pos_y, {3'b000, r2.pya},
                           r2.n.root.base.dy_neg);
    r3_next.pos.bx = nudge(r2.n.root.base.pair.b_pos_x, {3'b000, r2.pxb},
                           !r2.n.root.base.dx_neg);
    r3_next.pos.by = nudge(r2.n.root.base.pair.b_pos_y, {3'b000, r2.pyb},
                           !r2.n.root.base.dy_neg);
    r3_next.s = sprod[48:14];
  end

  always_comb begin
    dva_p = r3.s * r3.n.root.ra;
    dvb_p = r3.s * r3.n.root.rb;
    r4_next.n = r3.n;
    r4_next.sep = r3.sep;
    r4_next.bounce = r3.bounce;
    r4_next.pos = r3.pos;
    r4_next.dva = dva_p[64:30];
    r4_next.dvb = dvb_p[64:30];
    r4_next.hp = r3.s * r3.n.root.mu;
  end

  always_comb begin
    vxa_p = r4.dva * r4.n.nxm;
    vya_p = r4.dva * r4.n.nym;
    vxb_p = r4.dvb * r4.n.nxm;
    vyb_p = r4.dvb * r4.n.nym;
    q = r4.hp[63:0] >> HEAT_SHIFT;
    r5_next.n = r4.n;
    r5_next.sep = r4.sep;
    r5_next.bounce = r4.bounce;
    r5_next.pos = r4.pos;
    r5_next.vxa = vxa_p[64:30];
    r5_next.vya = vya_p[64:30];
    r5_next.vxb = vxb_p[64:30];
    r5_next.vyb = vyb_p[64:30];
    r5_next.hcap = (r4.hp[66:64] != '0) || (q >= HEAT_Q_CAP);
    r5_next.qk = q[19:0] * DIV25_K;
  end

  always_comb begin
    heat = r5.hcap ? TEMP_CAP : r5.qk[46:32];
    ta_sum = {1'b0, r5.n.root.base.pair.a_temp} + {1'b0, heat};
    tb_sum = {1'b0, r5.n.root.base.pair.b_temp} + {1'b0, heat};
    r6_next.new_a_pos_x = r5.n.root.base.pair.a_pos_x;
    r6_next.new_a_pos_y = r5.n.root.base.pair.a_pos_y;
    r6_next.new_b_pos_x = r5.n.root.base.pair.b_pos_x;
    r6_next.new_b_pos_y = r5.n.root.base.pair.b_pos_y;
    r6_next.new_a_vel_x = r5.n.root.base.pair.a_vel_x;
    r6_next.new_a_vel_y = r5.n.root.base.pair.a_vel_y;
    r6_next.new_b_vel_x = r5.n.root.base.pair.b_vel_x;
    r6_next.new_b_vel_y = r5.n.root.base.pair.b_vel_y;
    r6_next.new_a_temp = r5.n.root.base.pair.a_temp;
    r6_next.new_b_temp = r5.n.root.base.pair.b_temp;
    r6_next.outcome = OUTCOME_NONE;
    if (r5.n.root.base.contact) begin
      r6_next.outcome = OUTCOME_COINCIDENT;
    end
    if (r5.sep) begin
      r6_next.new_a_pos_x = r5.pos.ax;
      r6_next.new_a_pos_y = r5.pos.ay;
      r6_next.new_b_pos_x = r5.pos.bx;
      r6_next.new_b_pos_y = r5.pos.by;
      r6_next.outcome = OUTCOME_SEPARATED;
    end
    if (r5.bounce) begin
      r6_next.new_a_vel_x = nudge(r5.n.root.base.pair.a_vel_x, r5.vxa, r5.n.root.base.dx_neg);
      r6_next.new_a_vel_y = nudge(r5.n.root.base.pair.a_vel_y, r5.vya, r5.n.root.base.dy_neg);
      r6_next.new_b_vel_x = nudge(r5.n.root.base.pair.b_vel_x, r5.vxb, !r5.n.root.base.dx_neg);
      r6_next.new_b_vel_y = nudge(r5.n.root.base.pair.b_vel_y, r5.vyb, !r5.n.root.base.dy_neg);
      r6_next.new_a_temp = (ta_sum > {1'b0, TEMP_CAP}) ? TEMP_CAP : ta_sum[14:0];
      r6_next.new_b_temp = (tb_sum > {1'b0, TEMP_CAP}) ? TEMP_CAP : tb_sum[14:0];
      r6_next.outcome = OUTCOME_BOUNCED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
    if (adv) begin
      r1 <= r1_next;
      r2 <= r2_next;
      r3 <= r3_next;
      r4 <= r4_next;
      r5 <= r5_next;
      result <= r6_next;
    end
  end

  a_bounce_needs_sep: assert property (@(posedge clk) disable iff (rst)
    v2 && r2.bounce |-> r2.sep && r2.n.root.base.contact && (r2.n.root.d != '0))
    else $error("bounce without separation");

  a_temp_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.outcome == OUTCOME_BOUNCED) |->
      (result.new_a_temp <= TEMP_CAP) && (result.new_b_temp <= TEMP_CAP))
    else $error("temperature above cap after bounce");

endmodule

// ===== rtl/disc_pair_collision_resolver.sv =====
// Top level of the disc pair collision resolver: configuration registers,
// pipeline wiring and flow control. Depends on dpcr_pkg and the dpcr_* stages.
//
// Takes one disc pair per cycle while pair_ready is high and returns one
// result word per pair, in order, through 3 front stages (deltas, squares,
// contact test), 16 stages of square root and mass-ratio division, 16
// stages of normal division, 6 response stages. The square root and the
// dividers resolve two quotient bits per stage, which sets the depth. The
// whole pipeline advances together whenever the output register is empty
// or being taken, so pair_ready is low only while a result waits.
module disc_pair_collision_resolver #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  output logic                pair_ready,
  input  dpcr_pkg::dpcr_in_t  pair,
  output logic                result_valid,
  input  logic                result_ready,
  output dpcr_pkg::dpcr_out_t result,
  input  logic                cfg_wr_en,
  input  logic [0:0]          cfg_index,
  input  logic [30:0]         cfg_data
);
  import dpcr_pkg::*;

  localparam logic [30:0] RADIUS_RESET = 31'(1) << FRAC_BITS;

  logic        adv;
  logic [30:0] disc_radius;
  logic [14:0] restitution;
  logic        front_v;
  dpcr_front_t front_d;
  logic        root_v;
  dpcr_root_t  root_d;
  logic        norm_v;
  dpcr_norm_t  norm_d;

  assign adv = !result_valid || result_ready;
  assign pair_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_radius <= RADIUS_RESET;
      restitution <= ONE_Q14;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DISC_RADIUS: disc_radius <= cfg_data;
        REG_RESTITUTION: restitution <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  dpcr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (pair_valid),
    .pair        (pair),
    .disc_radius (disc_radius),
    .out_valid   (front_v),
    .front       (front_d)
  );

  dpcr_root u_root (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_v),
    .front     (front_d),
    .out_valid (root_v),
    .root      (root_d)
  );

  dpcr_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (root_v),
    .root      (root_d),
    .out_valid (norm_v),
    .norm      (norm_d)
  );

  dpcr_resp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_resp (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (norm_v),
    .norm        (norm_d),
    .disc_radius (disc_radius),
    .restitution (restitution),
    .out_valid   (result_valid),
    .result      (result)
  );

endmodule
